FILE: rtl/core/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and codes for the priority queue scheduler.
// ----------------------------------------------------------------------------
package pqs_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_EXEC   = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] name;
		logic [7:0]  prio;
		logic [15:0] burst;
	} pqs_entry_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INS  = 5'b00010,
		ST_PUT  = 5'b00100,
		ST_EXE  = 5'b01000,
		ST_FIN  = 5'b10000
	} pqs_state_t;

endpackage

FILE: rtl/core/priority_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_queue_scheduler_top
// Non-preemptive priority job queue held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Job channel (job_valid/job_stall) carries one request per transaction:
//   func 0 inserts a job (name, priority, burst), func 1 executes the head.
//   Result channel (res_valid/res_stall) returns exactly one transaction per
//   request: status, executed job name, completion time and queue count.
//   Jobs live in a circular buffer with a head pointer; an insert walks back
//   from the tail, one memory read and one write per cycle, moving entries
//   with a larger priority value up by one slot.
//   An execute passes ST_EXE then ST_FIN; a rejected or empty request goes
//   straight to ST_FIN; an insert runs ST_INS and/or ST_PUT before ST_FIN.
//   One request is in work at a time; job_stall is high until the result has
//   been placed in the output register. A new request is taken while that
//   result still waits for the receiver.
//   While res_stall is high the result holds; a finished request then waits
//   in its last state until the output register frees up.
//   Reset empties the queue and clears the elapsed time; memory contents are
//   not cleared since only occupied slots are ever read.
// ----------------------------------------------------------------------------
module priority_queue_scheduler_top
	import pqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_stall,
	input  logic        func,
	input  logic [15:0] job_name,
	input  logic [7:0]  job_priority,
	input  logic [15:0] job_burst,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [15:0] done_name,
	output logic [31:0] completion_time,
	output logic [4:0]  queue_count
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	pqs_state_t  state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] head_q;
	logic [31:0] elapsed_q;
	logic [15:0] nm_q;
	logic [7:0]  pr_q;
	logic [15:0] bt_q;
	logic [1:0]  rs_status_q;
	logic [15:0] rs_name_q;
	logic [31:0] rs_time_q;
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [15:0] done_name_q;
	logic [31:0] completion_time_q;
	logic [4:0]  queue_count_q;

	pqs_entry_t  mem [QUEUE_DEPTH];
	pqs_entry_t  rd_q;
	pqs_entry_t  wd;
	pqs_entry_t  new_entry;
	logic        we;
	logic        re;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	logic        acc;
	logic        out_free;
	logic        larger;
	logic [32:0] sum_w;
	logic [31:0] sat_time;
	logic [CW+4:0] cnt_ext;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [CW-1:0] x);
		logic [AW:0] s;
		s = {1'b0, head} + (AW + 1)'(x);
		if (s >= DEPTH_W)
			return AW'(s - DEPTH_W);
		else
			return AW'(s);
	endfunction

	assign acc       = job_valid && !job_stall;
	assign job_stall = (state_q != ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign larger    = (rd_q.prio > pr_q);
	assign new_entry = '{name: nm_q, prio: pr_q, burst: bt_q};
	assign sum_w     = {1'b0, elapsed_q} + 33'(rd_q.burst);
	assign sat_time  = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
	assign cnt_ext   = (CW + 5)'(cnt_q);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = phys(head_q, k_q);
		wd = new_entry;
		ra = head_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cnt_q != '0) begin
					if (func == FUNC_EXEC) begin
						re = 1'b1;
					end else if (cnt_q != DEPTH_C) begin
						re = 1'b1;
						ra = phys(head_q, cnt_q - CW'(1));
					end
				end
			end
			ST_INS: begin
				we = 1'b1;
				if (larger) begin
					wd = rd_q;
					if (k_q != CW'(1)) begin
						re = 1'b1;
						ra = phys(head_q, k_q - CW'(2));
					end
				end
			end
			ST_PUT: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			cnt_q             <= '0;
			k_q               <= '0;
			head_q            <= '0;
			elapsed_q         <= '0;
			nm_q              <= '0;
			pr_q              <= '0;
			bt_q              <= '0;
			rs_status_q       <= STATUS_OK;
			rs_name_q         <= '0;
			rs_time_q         <= '0;
			res_valid_q       <= 1'b0;
			status_q          <= STATUS_OK;
			done_name_q       <= '0;
			completion_time_q <= '0;
			queue_count_q     <= '0;
		end else begin
			if (state_q == ST_FIN && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						nm_q      <= job_name;
						pr_q      <= job_priority;
						bt_q      <= job_burst;
						rs_name_q <= '0;
						rs_time_q <= '0;
						if (func == FUNC_EXEC) begin
							if (cnt_q == '0) begin
								rs_status_q <= STATUS_EMPTY;
								state_q     <= ST_FIN;
							end else begin
								state_q <= ST_EXE;
							end
						end else if (cnt_q == DEPTH_C) begin
							rs_status_q <= STATUS_FULL;
							state_q     <= ST_FIN;
						end else if (cnt_q == '0) begin
							k_q     <= '0;
							state_q <= ST_PUT;
						end else begin
							k_q     <= cnt_q;
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if (larger) begin
						k_q <= k_q - CW'(1);
						if (k_q == CW'(1))
							state_q <= ST_PUT;
					end else begin
						cnt_q       <= cnt_q + CW'(1);
						rs_status_q <= STATUS_OK;
						state_q     <= ST_FIN;
					end
				end
				ST_PUT: begin
					cnt_q       <= cnt_q + CW'(1);
					rs_status_q <= STATUS_OK;
					state_q     <= ST_FIN;
				end
				ST_EXE: begin
					elapsed_q   <= sat_time;
					head_q      <= phys(head_q, CW'(1));
					cnt_q       <= cnt_q - CW'(1);
					rs_status_q <= STATUS_OK;
					rs_name_q   <= rd_q.name;
					rs_time_q   <= sat_time;
					state_q     <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						status_q          <= rs_status_q;
						done_name_q       <= rs_name_q;
						completion_time_q <= rs_time_q;
						queue_count_q     <= cnt_ext[4:0];
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid       = res_valid_q;
	assign status          = status_q;
	assign done_name       = done_name_q;
	assign completion_time = completion_time_q;
	assign queue_count     = queue_count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("job count exceeds queue depth");

	a_elapsed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 elapsed_q >= $past(elapsed_q))
		else $error("elapsed time decreased");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != ST_IDLE)
		else $error("accepted transaction left no work");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q != STATUS_OK |-> done_name_q == '0 &&
			completion_time_q == '0)
		else $error("failed request reports a job");

endmodule

FILE: test/priority_queue_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_queue_scheduler_top_tb
// Self-checking bench for the priority job queue. A short table of requests
// covers the empty, full and equal-priority cases. Random requests then fill
// and drain the queue, and a closing run of maximum bursts goes back to back.
// Every result is compared with its table row or a local scheduler model.
// ----------------------------------------------------------------------------
module priority_queue_scheduler_top_tb;
	import pqs_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int STUCK_LIMIT  = 100 * (QUEUE_DEPTH + 4);
	localparam int RANDOM_JOBS  = 1500;
	localparam int SAT_PAIRS    = 16;

	typedef struct packed {
		logic [1:0]  code;
		logic [15:0] job;
		logic [31:0] finish_time;
		logic [4:0]  fill;
	} sched_result_t;

	typedef struct {
		logic          f;
		logic [15:0]   nm;
		logic [7:0]    pr;
		logic [15:0]   bt;
		bit            typed;
		sched_result_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        job_valid = 1'b0;
	logic        job_stall;
	logic        func = FUNC_INSERT;
	logic [15:0] job_name = '0;
	logic [7:0]  job_priority = '0;
	logic [15:0] job_burst = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] done_name;
	logic [31:0] completion_time;
	logic [4:0]  queue_count;

	pqs_entry_t    job_slots[QUEUE_DEPTH];
	int            jobs_held = 0;
	logic [31:0]   elapsed_ticks = '0;
	sched_result_t awaited_results[$];
	dir_row_t      dir_rows[$];

	int idle_pct = 16;
	int stuck_cycles = 0;
	int mismatch_count = 0;
	int jobs_sent = 0;
	int results_seen = 0;
	int full_rejects = 0;
	int empty_execs = 0;
	int peak_fill = 0;

	priority_queue_scheduler_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.func(func),
		.job_name(job_name),
		.job_priority(job_priority),
		.job_burst(job_burst),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.done_name(done_name),
		.completion_time(completion_time),
		.queue_count(queue_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic sched_result_t schedule_job(logic f, logic [15:0] nm,
			logic [7:0] pr, logic [15:0] bt);
		sched_result_t r;
		pqs_entry_t    e;
		logic [32:0]   sum;
		int            pos;
		int            k;
		r = '0;
		if (f == FUNC_INSERT) begin
			if (jobs_held >= QUEUE_DEPTH) begin
				r.code = STATUS_FULL;
				full_rejects++;
			end else begin
				pos = 0;
				while (pos < jobs_held && job_slots[pos].prio <= pr)
					pos++;
				for (k = jobs_held; k > pos; k--)
					job_slots[k] = job_slots[k - 1];
				e.name = nm;
				e.prio = pr;
				e.burst = bt;
				job_slots[pos] = e;
				jobs_held++;
				if (jobs_held > peak_fill)
					peak_fill = jobs_held;
				r.code = STATUS_OK;
			end
		end else if (jobs_held == 0) begin
			r.code = STATUS_EMPTY;
			empty_execs++;
		end else begin
			e = job_slots[0];
			sum = {1'b0, elapsed_ticks} + {17'b0, e.burst};
			elapsed_ticks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			for (k = 1; k < jobs_held; k++)
				job_slots[k - 1] = job_slots[k];
			jobs_held--;
			r.code = STATUS_OK;
			r.job = e.name;
			r.finish_time = elapsed_ticks;
		end
		r.fill = jobs_held[4:0];
		return r;
	endfunction

	function automatic void add_row(logic f, logic [15:0] nm, logic [7:0] pr,
			logic [15:0] bt, bit typed, logic [1:0] code, logic [15:0] job,
			logic [31:0] finish_time, logic [4:0] fill);
		dir_row_t row;
		row.f = f;
		row.nm = nm;
		row.pr = pr;
		row.bt = bt;
		row.typed = typed;
		row.res.code = code;
		row.res.job = job;
		row.res.finish_time = finish_time;
		row.res.fill = fill;
		dir_rows.push_back(row);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic send_job(input logic f, input logic [15:0] nm, input logic [7:0] pr,
			input logic [15:0] bt, input bit typed, input sched_result_t typed_res);
		sched_result_t want;
		while ($urandom_range(99) < idle_pct) begin
			job_valid <= 1'b0;
			@(posedge clk);
		end
		job_valid <= 1'b1;
		func <= f;
		job_name <= nm;
		job_priority <= pr;
		job_burst <= bt;
		@(posedge clk);
		while (job_stall)
			@(posedge clk);
		want = schedule_job(f, nm, pr, bt);
		awaited_results.push_back(typed ? typed_res : want);
		jobs_sent++;
	endtask

	task automatic drain_results();
		job_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if ((job_valid && !job_stall) || (res_valid && !res_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	always @(posedge clk) begin
		sched_result_t want;
		if (res_valid && !res_stall) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch("result transaction with nothing awaited");
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.code)
					report_mismatch($sformatf("status got %0d want %0d",
						status, want.code));
				if (done_name !== want.job)
					report_mismatch($sformatf("done_name got %h want %h",
						done_name, want.job));
				if (completion_time !== want.finish_time)
					report_mismatch($sformatf("completion_time got %0d want %0d",
						completion_time, want.finish_time));
				if (queue_count !== want.fill)
					report_mismatch($sformatf("queue_count got %0d want %0d",
						queue_count, want.fill));
			end
		end
		res_stall <= ($urandom_range(99) < idle_pct);
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int            mix_pct[6];
		int            i;
		int            ins_pct;
		int            dir_count;
		logic          f;
		logic [15:0]   nm;
		logic [7:0]    pr;
		logic [15:0]   bt;
		logic [31:0]   draw;
		sched_result_t no_res;

		mix_pct = '{85, 50, 15, 70, 95, 30};
		no_res = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		//       func         name      prio   burst     typed  status        name      time   fill
		add_row(FUNC_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b1, STATUS_EMPTY, 16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, STATUS_OK,    16'h0000, 32'd0, 5'd1);
		add_row(FUNC_INSERT, 16'h0000, 8'h00, 16'h0000, 1'b1, STATUS_OK,    16'h0000, 32'd0, 5'd2);
		add_row(FUNC_INSERT, 16'h4142, 8'h80, 16'h1234, 1'b1, STATUS_OK,    16'h0000, 32'd0, 5'd3);
		add_row(FUNC_INSERT, 16'h4344, 8'h80, 16'h0001, 1'b1, STATUS_OK,    16'h0000, 32'd0, 5'd4);
		add_row(FUNC_INSERT, 16'h4a30, 8'h7F, 16'h0100, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a31, 8'h01, 16'h0200, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a32, 8'hFE, 16'h8000, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a33, 8'h80, 16'h0003, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a34, 8'h40, 16'h7FFF, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a35, 8'h00, 16'h0010, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a36, 8'hFF, 16'h0020, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a37, 8'h10, 16'h5555, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a38, 8'h80, 16'hAAAA, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4a39, 8'h20, 16'h00FF, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4b30, 8'h7F, 16'hFF00, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h4b31, 8'h01, 16'h0F0F, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_INSERT, 16'h5858, 8'h00, 16'hFFFF, 1'b1, STATUS_FULL,  16'h0000, 32'd0, 5'd16);
		add_row(FUNC_EXEC,   16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, STATUS_OK,    16'h0000, 32'd0, 5'd15);
		add_row(FUNC_EXEC,   16'h1234, 8'h5A, 16'hA5A5, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);
		add_row(FUNC_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b0, STATUS_OK,    16'h0000, 32'd0, 5'd0);

		foreach (dir_rows[i])
			send_job(dir_rows[i].f, dir_rows[i].nm, dir_rows[i].pr, dir_rows[i].bt,
				dir_rows[i].typed, dir_rows[i].res);
		dir_count = jobs_sent;
		drain_results();

		// insert share shifts every block so the queue swings between full and empty
		for (i = 0; i < RANDOM_JOBS; i++) begin
			idle_pct = (i >= 600 && i < 900) ? 0 : 16;
			ins_pct = mix_pct[(i / 125) % 6];
			f = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_EXEC;
			draw = $urandom;
			nm = draw[15:0];
			draw = $urandom;
			pr = ($urandom_range(3) == 0) ? draw[7:0] : {5'b0, draw[10:8]};
			bt = draw[31:16];
			send_job(f, nm, pr, bt, 1'b0, no_res);
			if (i == 750)
				drain_results();
		end
		drain_results();

		// back-to-back maximum bursts close the run
		idle_pct = 0;
		for (i = 0; i < SAT_PAIRS; i++) begin
			draw = $urandom;
			send_job(FUNC_INSERT, draw[15:0], draw[23:16], 16'hFFFF, 1'b0, no_res);
			send_job(FUNC_EXEC, draw[31:16], draw[7:0], draw[15:0], 1'b0, no_res);
		end
		drain_results();
		repeat (QUEUE_DEPTH + 4) @(posedge clk);

		$display("run covered %0d requests (%0d from the table, %0d random), %0d results",
			jobs_sent, dir_count, RANDOM_JOBS, results_seen);
		$display("peak fill %0d of %0d, %0d full rejects, %0d empty executes, elapsed %0d",
			peak_fill, QUEUE_DEPTH, full_rejects, empty_execs, elapsed_ticks);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/pqs_pkg.sv
rtl/core/priority_queue_scheduler_top.sv
test/priority_queue_scheduler_top_tb.sv
